// ===== src/pri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition ratio interpolator package
// Shared types, field widths, register codes and pipeline depths.
// ----------------------------------------------------------------------------
package pri_pkg;

  localparam int T_BITS        = 18;
  localparam int T_FRAC        = 8;
  localparam int KELVIN_BITS   = 10;
  localparam int STEP_BITS     = 8;
  localparam int INDEX_BITS    = 7;
  localparam int RATIO_BITS    = 24;
  localparam int FRAC_BITS     = 20;

  localparam int Q_BITS        = 2 * RATIO_BITS;
  localparam int SAT_SHIFT     = Q_BITS - 2 * FRAC_BITS;
  localparam int CUBE_BITS     = 3 * T_BITS;
  localparam int SQRT_REM_BITS = RATIO_BITS + 2;
  localparam int D_BITS        = STEP_BITS + T_FRAC;
  localparam int PROD_BITS     = RATIO_BITS + D_BITS;

  // Register stages from the input register of each path to its result.
  localparam int POW_LAT       = 3 + Q_BITS + RATIO_BITS;
  localparam int INTERP_LAT    = 1 + KELVIN_BITS + 3 + 1 + RATIO_BITS;
  // Clock edges from the accepting edge to the edge that takes the result.
  localparam int RESULT_LAT    = POW_LAT + 2;

  localparam logic [KELVIN_BITS-1:0] GRID_MIN_RESET = 10'd160;
  localparam logic [KELVIN_BITS-1:0] GRID_MAX_RESET = 10'd320;
  localparam logic [STEP_BITS-1:0]   GRID_STEP_RESET = 8'd2;
  localparam logic [KELVIN_BITS-1:0] REF_TEMP_RESET = 10'd296;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_GRID_MIN  = 2'd0,
    CFG_GRID_MAX  = 2'd1,
    CFG_GRID_STEP = 2'd2,
    CFG_REF_TEMP  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    op_t                    op;
    logic [T_BITS-1:0]      temperature;
    logic [INDEX_BITS-1:0]  entry_index;
    logic [RATIO_BITS-1:0]  entry_value;
  } cmd_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] ratio;
    logic                  out_of_range;
    logic                  saturated;
  } result_t;

endpackage

// ===== src/partition_ratio_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition ratio interpolator
// Table of ratios on a uniform temperature grid, with linear interpolation
// inside the grid and a (Tref/T)^1.5 power law outside it.
// ----------------------------------------------------------------------------
// The block takes one command in every clock cycle once reset is over: busy
// is high during reset and for the cycle that follows it, and is otherwise
// low, since the result side cannot be stalled and so never pushes back. A
// write command loads one table entry and gives no result. An evaluate
// command gives one result, shown for a single cycle with result_valid;
// results leave in command order. The power-law path, a 48-stage restoring
// divider followed by a 24-stage square root, one bit per stage, is the
// longer one; the interpolation path is delay-matched to it. Configuration
// registers should only be written while no command is in flight. Table
// entries read before they are written give undefined ratios.
// ----------------------------------------------------------------------------
module partition_ratio_interpolator
  import pri_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  cmd_t                   cmd,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  cfg_index_t             cfg_index,
  input  logic [KELVIN_BITS-1:0] cfg_data,
  output logic                   result_valid,
  output result_t                result
);

  localparam int ADDR_W    = $clog2(TABLE_DEPTH);
  localparam int IW        = (ADDR_W > KELVIN_BITS) ? ADDR_W : KELVIN_BITS;
  localparam int DELAY_LEN = POW_LAT - INTERP_LAT;

  // Grid divider stage: grid index and last grid index share the step.
  typedef struct packed {
    logic                   valid;
    op_t                    op;
    logic [INDEX_BITS-1:0]  idx;
    logic [RATIO_BITS-1:0]  value;
    logic                   oor;
    logic [T_FRAC-1:0]      off_lo;
    logic [STEP_BITS-1:0]   step;
    logic [KELVIN_BITS-1:0] ni;
    logic [STEP_BITS-1:0]   ri;
    logic [KELVIN_BITS-1:0] nl;
    logic [STEP_BITS-1:0]   rl;
  } grid_div_t;

  // Ratio divider stage: the weighted sum divided by the grid spacing.
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic                  oor;
    logic                  at_top;
    logic [RATIO_BITS-1:0] top;
    logic [D_BITS-1:0]     d;
    logic [D_BITS-1:0]     rem;
    logic [RATIO_BITS-1:0] n;
  } ratio_div_t;

  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic                  oor;
    logic [RATIO_BITS-1:0] ratio;
  } interp_out_t;

  function automatic grid_div_t grid_div_step(grid_div_t s);
    grid_div_t          o;
    logic [STEP_BITS:0] ti;
    logic [STEP_BITS:0] tl;
    o  = s;
    ti = {s.ri, s.ni[KELVIN_BITS-1]};
    tl = {s.rl, s.nl[KELVIN_BITS-1]};
    if (ti >= {1'b0, s.step}) begin
      o.ri = STEP_BITS'(ti - {1'b0, s.step});
      o.ni = {s.ni[KELVIN_BITS-2:0], 1'b1};
    end else begin
      o.ri = ti[STEP_BITS-1:0];
      o.ni = {s.ni[KELVIN_BITS-2:0], 1'b0};
    end
    if (tl >= {1'b0, s.step}) begin
      o.rl = STEP_BITS'(tl - {1'b0, s.step});
      o.nl = {s.nl[KELVIN_BITS-2:0], 1'b1};
    end else begin
      o.rl = tl[STEP_BITS-1:0];
      o.nl = {s.nl[KELVIN_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic ratio_div_t ratio_div_step(ratio_div_t s);
    ratio_div_t      o;
    logic [D_BITS:0] tr;
    o  = s;
    tr = {s.rem, s.n[RATIO_BITS-1]};
    if (tr >= {1'b0, s.d}) begin
      o.rem = D_BITS'(tr - {1'b0, s.d});
      o.n   = {s.n[RATIO_BITS-2:0], 1'b1};
    end else begin
      o.rem = tr[D_BITS-1:0];
      o.n   = {s.n[RATIO_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  // Configuration registers.
  logic [KELVIN_BITS-1:0] grid_min_temp;
  logic [KELVIN_BITS-1:0] grid_max_temp;
  logic [STEP_BITS-1:0]   grid_step;
  logic [KELVIN_BITS-1:0] reference_temp;

  // Input register.
  logic s0_valid;
  cmd_t s0_cmd;

  // Grid lookup and interpolation path.
  grid_div_t              dv [KELVIN_BITS+1];
  grid_div_t              dv_last;
  logic [T_BITS-1:0]      tmin, tmax, off;
  logic [IW-1:0]          last_raw, last_c, idx_i;
  logic                   at_top_b;

  logic                   b_valid, b_oor, b_at_top, b_we;
  op_t                    b_op;
  logic [D_BITS-1:0]      b_r, b_d;
  logic [ADDR_W-1:0]      b_addr0, b_addr1, b_waddr;
  logic [RATIO_BITS-1:0]  b_wdata;

  logic                   c_valid, c_oor, c_at_top;
  op_t                    c_op;
  logic [D_BITS-1:0]      c_r, c_d, c_dr;
  logic [RATIO_BITS-1:0]  q0, q1;

  logic                   d_valid, d_oor, d_at_top;
  op_t                    d_op;
  logic [D_BITS-1:0]      d_d;
  logic [RATIO_BITS-1:0]  d_top;
  logic [PROD_BITS-1:0]   d_p0, d_p1, sum;

  ratio_div_t             rq [RATIO_BITS+1];
  interp_out_t            dl_in;
  interp_out_t            dl [DELAY_LEN+1];

  logic [RATIO_BITS-1:0]  pw_ratio;
  logic                   pw_sat;

  // Busy covers reset and the cycle after it; afterwards a command is taken in
  // every cycle. The configuration channel follows the same rule.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_min_temp  <= GRID_MIN_RESET;
      grid_max_temp  <= GRID_MAX_RESET;
      grid_step      <= GRID_STEP_RESET;
      reference_temp <= REF_TEMP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_MIN:  grid_min_temp  <= cfg_data;
        CFG_GRID_MAX:  grid_max_temp  <= cfg_data;
        CFG_GRID_STEP: grid_step      <= cfg_data[STEP_BITS-1:0];
        CFG_REF_TEMP:  reference_temp <= cfg_data;
      endcase
    end
  end

  // Every command transfer is registered here first; both paths start from
  // this register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
    s0_cmd <= cmd;
  end

  // Range check and offset from the bottom of the grid. The offset is split
  // into whole kelvin, which go through the divider, and the fraction, which
  // becomes the low byte of the remainder.
  assign tmin = {grid_min_temp, {T_FRAC{1'b0}}};
  assign tmax = {grid_max_temp, {T_FRAC{1'b0}}};
  assign off  = s0_cmd.temperature - tmin;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0].valid  <= s0_valid;
      dv[0].op     <= s0_cmd.op;
      dv[0].idx    <= s0_cmd.entry_index;
      dv[0].value  <= s0_cmd.entry_value;
      dv[0].oor    <= (s0_cmd.temperature < tmin) || (s0_cmd.temperature > tmax);
      dv[0].off_lo <= off[T_FRAC-1:0];
      // A step of zero behaves as a step of one.
      dv[0].step   <= (grid_step == '0) ? STEP_BITS'(1) : grid_step;
      dv[0].ni     <= off[T_BITS-1:T_FRAC];
      dv[0].ri     <= '0;
      // When the minimum lies above the maximum everything is out of range,
      // so the wrapped difference is never used.
      dv[0].nl     <= grid_max_temp - grid_min_temp;
      dv[0].rl     <= '0;
    end
  end

  for (genvar k = 0; k < KELVIN_BITS; k++) begin : g_grid_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].valid <= 1'b0;
      end else begin
        dv[k+1] <= grid_div_step(dv[k]);
      end
    end
  end

  assign dv_last = dv[KELVIN_BITS];

  // The last grid index is clipped to the table. At or past it the entry is
  // returned as it stands, which also covers a temperature equal to the
  // maximum and a maximum that falls between grid points.
  assign last_raw = IW'(dv_last.nl);
  assign last_c   = (last_raw > IW'(TABLE_DEPTH - 1)) ? IW'(TABLE_DEPTH - 1) : last_raw;
  assign idx_i    = IW'(dv_last.ni);
  assign at_top_b = (idx_i >= last_c);

  // Address stage. Table writes travel down the pipe with the evaluations so
  // that they reach the table in command order.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_we    <= 1'b0;
    end else begin
      b_valid <= dv_last.valid;
      b_we    <= dv_last.valid && (dv_last.op == OP_WRITE) &&
                 (32'(dv_last.idx) < 32'(TABLE_DEPTH));
    end
    b_op     <= dv_last.op;
    b_oor    <= dv_last.oor;
    b_at_top <= at_top_b;
    b_r      <= {dv_last.ri, dv_last.off_lo};
    b_d      <= {dv_last.step, {T_FRAC{1'b0}}};
    b_addr0  <= at_top_b ? ADDR_W'(last_c) : ADDR_W'(idx_i);
    b_addr1  <= ADDR_W'(idx_i + IW'(1));
    b_waddr  <= ADDR_W'(dv_last.idx);
    b_wdata  <= dv_last.value;
  end

  pri_ram #(
    .WIDTH (RATIO_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (b_we),
    .waddr   (b_waddr),
    .wdata   (b_wdata),
    .raddr_a (b_addr0),
    .raddr_b (b_addr1),
    .rdata_a (q0),
    .rdata_b (q1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_op     <= b_op;
    c_oor    <= b_oor;
    c_at_top <= b_at_top;
    c_r      <= b_r;
    c_d      <= b_d;
  end

  assign c_dr = c_d - c_r;

  // Weights of the two neighbouring entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_op     <= c_op;
    d_oor    <= c_oor;
    d_at_top <= c_at_top;
    d_d      <= c_d;
    d_top    <= q0;
    d_p0     <= q0 * c_dr;
    d_p1     <= q1 * c_r;
  end

  // Adding half the spacing makes the division round to nearest, ties up.
  // The quotient stays below 2^24, so the upper part is below the divisor.
  assign sum = d_p0 + d_p1 + PROD_BITS'(d_d >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rq[0].valid <= 1'b0;
    end else begin
      rq[0].valid  <= d_valid;
      rq[0].op     <= d_op;
      rq[0].oor    <= d_oor;
      rq[0].at_top <= d_at_top;
      rq[0].top    <= d_top;
      rq[0].d      <= d_d;
      rq[0].rem    <= sum[PROD_BITS-1:RATIO_BITS];
      rq[0].n      <= sum[RATIO_BITS-1:0];
    end
  end

  for (genvar k = 0; k < RATIO_BITS; k++) begin : g_ratio_div
    always_ff @(posedge clk) begin
      if (rst) begin
        rq[k+1].valid <= 1'b0;
      end else begin
        rq[k+1] <= ratio_div_step(rq[k]);
      end
    end
  end

  always_comb begin
    dl_in.valid = rq[RATIO_BITS].valid;
    dl_in.op    = rq[RATIO_BITS].op;
    dl_in.oor   = rq[RATIO_BITS].oor;
    dl_in.ratio = rq[RATIO_BITS].at_top ? rq[RATIO_BITS].top : rq[RATIO_BITS].n;
    dl[0]       = dl_in;
  end

  // Delay line that lines the interpolation result up with the power law.
  for (genvar k = 0; k < DELAY_LEN; k++) begin : g_delay
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          dl[1].valid <= 1'b0;
        end else begin
          dl[1] <= dl_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          dl[k+1].valid <= 1'b0;
        end else begin
          dl[k+1] <= dl[k];
        end
      end
    end
  end

  // The power law runs for every command; its answer is used only for an
  // evaluation outside the grid.
  pri_power u_power (
    .clk   (clk),
    .t     (s0_cmd.temperature),
    .tref  (reference_temp),
    .ratio (pw_ratio),
    .sat   (pw_sat)
  );

  // Result register: one strobe per evaluation, none per table write.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= dl[DELAY_LEN].valid && (dl[DELAY_LEN].op == OP_EVAL);
    end
    result.ratio        <= dl[DELAY_LEN].oor ? pw_ratio : dl[DELAY_LEN].ratio;
    result.out_of_range <= dl[DELAY_LEN].oor;
    result.saturated    <= dl[DELAY_LEN].oor && pw_sat;
  end

endmodule

// ===== src/pri_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module pri_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/pri_power.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-law pipeline
// Computes floor((Tref/T)^1.5) in Q4.20 with saturation, one bit a stage.
// ----------------------------------------------------------------------------
module pri_power
  import pri_pkg::*;
(
  input  logic                   clk,
  input  logic [T_BITS-1:0]      t,
  input  logic [KELVIN_BITS-1:0] tref,
  output logic [RATIO_BITS-1:0]  ratio,
  output logic                   sat
);

  typedef struct packed {
    logic                 sat;
    logic [CUBE_BITS-1:0] den;
    logic [CUBE_BITS-1:0] rem;
    logic [Q_BITS-1:0]    n;
  } pdiv_t;

  typedef struct packed {
    logic                     sat;
    logic [Q_BITS-1:0]        q;
    logic [SQRT_REM_BITS-1:0] rm;
    logic [RATIO_BITS-1:0]    y;
  } psqrt_t;

  function automatic pdiv_t div_step(pdiv_t s);
    pdiv_t              o;
    logic [CUBE_BITS:0] tr;
    o  = s;
    tr = {s.rem, s.n[Q_BITS-1]};
    if (tr >= {1'b0, s.den}) begin
      o.rem = CUBE_BITS'(tr - {1'b0, s.den});
      o.n   = {s.n[Q_BITS-2:0], 1'b1};
    end else begin
      o.rem = tr[CUBE_BITS-1:0];
      o.n   = {s.n[Q_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic psqrt_t sqrt_step(psqrt_t s);
    psqrt_t                   o;
    logic [SQRT_REM_BITS+1:0] tr;
    logic [SQRT_REM_BITS-1:0] trial;
    o     = s;
    tr    = {s.rm, s.q[Q_BITS-1:Q_BITS-2]};
    trial = {s.y, 2'b01};
    o.q   = {s.q[Q_BITS-3:0], 2'b00};
    if (tr >= (SQRT_REM_BITS + 2)'(trial)) begin
      o.rm = SQRT_REM_BITS'(tr - (SQRT_REM_BITS + 2)'(trial));
      o.y  = {s.y[RATIO_BITS-2:0], 1'b1};
    end else begin
      o.rm = tr[SQRT_REM_BITS-1:0];
      o.y  = {s.y[RATIO_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [2*T_BITS-1:0]  a_sq, t_sq;
  logic [T_BITS-1:0]    a1, t1;
  logic                 z1, z2;
  logic [CUBE_BITS-1:0] num, den;
  pdiv_t                dv [Q_BITS+1];
  psqrt_t               sq [RATIO_BITS+1];
  psqrt_t               sq_in;

  // Squares, then cubes, each behind its own register.
  always_ff @(posedge clk) begin
    a_sq <= {tref, {T_FRAC{1'b0}}} * {tref, {T_FRAC{1'b0}}};
    t_sq <= t * t;
    a1   <= {tref, {T_FRAC{1'b0}}};
    t1   <= t;
    z1   <= (t == '0);
    num  <= a_sq * a1;
    den  <= t_sq * t1;
    z2   <= z1;
  end

  // The quotient reaches 2^48 exactly when num >= den * 2^8; otherwise the
  // upper part of the dividend is already below the divisor.
  always_ff @(posedge clk) begin
    dv[0].sat <= z2 || ({{SAT_SHIFT{1'b0}}, num} >= {den, {SAT_SHIFT{1'b0}}});
    dv[0].den <= den;
    dv[0].rem <= CUBE_BITS'(num >> SAT_SHIFT);
    dv[0].n   <= {num[SAT_SHIFT-1:0], {(2 * FRAC_BITS){1'b0}}};
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      dv[k+1] <= div_step(dv[k]);
    end
  end

  always_comb begin
    sq_in.sat = dv[Q_BITS].sat;
    sq_in.q   = dv[Q_BITS].n;
    sq_in.rm  = '0;
    sq_in.y   = '0;
  end

  for (genvar k = 0; k < RATIO_BITS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        sq[1] <= sqrt_step(sq_in);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        sq[k+1] <= sqrt_step(sq[k]);
      end
    end
  end

  // Entry zero of the root chain is never used; keep it defined.
  always_comb begin
    sq[0] = sq_in;
  end

  assign ratio = sq[RATIO_BITS].sat ? {RATIO_BITS{1'b1}} : sq[RATIO_BITS].y;
  assign sat   = sq[RATIO_BITS].sat;

endmodule

// ===== src/pri_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partition ratio interpolator checker
// Port-level properties of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module pri_checker
  import pri_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input logic    result_valid,
  input result_t result
);

  localparam int WARM_W = $clog2(RESULT_LAT + 1);

  logic [WARM_W-1:0] warm;
  logic              settled;

  // Counts edges since reset, so that a command lost to a reset is not
  // expected to come out.
  always_ff @(posedge clk) begin
    if (rst) begin
      warm <= '0;
    end else if (warm != WARM_W'(RESULT_LAT)) begin
      warm <= warm + WARM_W'(1);
    end
  end

  assign settled = (warm == WARM_W'(RESULT_LAT));

  a_eval_gives_result : assert property (@(posedge clk) disable iff (rst)
    settled && $past(start && !busy && cmd.op == OP_EVAL, RESULT_LAT) |-> result_valid)
    else $error("evaluation transfer gave no result");

  a_write_gives_none : assert property (@(posedge clk) disable iff (rst)
    settled && $past(!(start && !busy && cmd.op == OP_EVAL), RESULT_LAT) |-> !result_valid)
    else $error("result without an evaluation transfer");

  a_sat_out_of_range : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |-> result.out_of_range)
    else $error("saturated result inside the grid");

  a_sat_is_max : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |-> result.ratio == {RATIO_BITS{1'b1}})
    else $error("saturated result below the maximum ratio");

endmodule

bind partition_ratio_interpolator pri_checker u_pri_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result       (result)
);
